// File: hdl/mam_pkg.sv
// ----------------------------------------------------------------------------
// mam_pkg
// shared constants, control word layout and bus helpers for the
// microprogrammed accumulator machine
// ----------------------------------------------------------------------------
package mam_pkg;

  localparam int RAM_WORDS   = 256;
  localparam int CTRL_WORDS  = 32;
  localparam int MAP_ENTRIES = 16;

  localparam int RAM_AW  = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
  localparam int CTRL_AW = (CTRL_WORDS > 1) ? $clog2(CTRL_WORDS) : 1;
  localparam int MAP_AW  = $clog2(MAP_ENTRIES);

  localparam int REQ_W   = 3;
  localparam int ADDR_W  = 8;
  localparam int DATA_W  = 24;
  localparam int WORD_W  = 12;
  localparam int UADDR_W = 5;

  localparam logic [REQ_W-1:0] REQ_STEP      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_RAM  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD_CTRL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOAD_MAP  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_RAM  = 3'd4;

  // ip sits in bit 23, jump address in bits 4..0
  typedef struct packed {
    logic ip;
    logic lp;
    logic ep;
    logic lm;
    logic rd;
    logic wr;
    logic ld;
    logic ed;
    logic li;
    logic ei;
    logic la;
    logic ea;
    logic add;
    logic sub;
    logic eu;
    logic lb;
    logic cd;
    logic map;
    logic hlt;
    logic [UADDR_W-1:0] jump;
  } cw_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pc;
    logic [ADDR_W-1:0]  mar;
    logic [WORD_W-1:0]  mdr;
    logic [WORD_W-1:0]  acc;
    logic [WORD_W-1:0]  alu;
    logic [WORD_W-1:0]  b;
    logic [WORD_W-1:0]  ir;
    logic [WORD_W-1:0]  bus;
    logic [UADDR_W-1:0] upc;
    logic               halt;
  } mach_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              ctrl_en;
    logic              map_en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ld_wr_t;

  function automatic logic ram_in_range(logic [ADDR_W-1:0] a);
    return int'(a) < RAM_WORDS;
  endfunction

  // eu has the last word on the bus, then ea, ei, ed, ep
  function automatic logic [WORD_W-1:0] bus_drive(cw_t cw, mach_t s);
    logic [WORD_W-1:0] v;
    v = s.bus;
    if (cw.ep) v = {{(WORD_W-ADDR_W){1'b0}}, s.pc};
    if (cw.ed) v = s.mdr;
    if (cw.ei) v = {{(WORD_W-ADDR_W){1'b0}}, s.ir[ADDR_W-1:0]};
    if (cw.ea) v = s.acc;
    if (cw.eu) v = s.alu;
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] mar_load(cw_t cw, mach_t s);
    logic [WORD_W-1:0] v;
    v = bus_drive(cw, s);
    return cw.lm ? v[ADDR_W-1:0] : s.mar;
  endfunction

endpackage

// File: hdl/mam_main_mem.sv
// ----------------------------------------------------------------------------
// mam_main_mem
// main memory with registered read, per-word written flags and
// same-edge write forwarding
// ----------------------------------------------------------------------------
module mam_main_mem (
  input  logic                              clk,
  input  logic                              rst,
  input  mam_pkg::ram_wr_t                  wr,
  input  logic                              rd_en,
  input  logic [mam_pkg::ADDR_W-1:0]        rd_addr,
  output logic [mam_pkg::WORD_W-1:0]        rd_data
);

  logic [mam_pkg::WORD_W-1:0]    mem [mam_pkg::RAM_WORDS];
  logic [mam_pkg::RAM_WORDS-1:0] written;
  logic [mam_pkg::WORD_W-1:0]    rd_word;
  logic [mam_pkg::WORD_W-1:0]    fwd_data;
  logic                          rd_hit;
  logic                          rd_fwd;
  logic                          wr_ok;
  logic                          rd_ok;

  assign wr_ok = wr.en && mam_pkg::ram_in_range(wr.addr);
  assign rd_ok = mam_pkg::ram_in_range(rd_addr);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.addr[mam_pkg::RAM_AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_word  <= mem[rd_addr[mam_pkg::RAM_AW-1:0]];
      fwd_data <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
      rd_fwd  <= 1'b0;
    end else begin
      if (wr_ok) begin
        written[wr.addr[mam_pkg::RAM_AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= rd_ok && written[rd_addr[mam_pkg::RAM_AW-1:0]];
        rd_fwd <= rd_ok && wr_ok && (wr.addr == rd_addr);
      end
    end
  end

  assign rd_data = rd_fwd ? fwd_data : (rd_hit ? rd_word : '0);

endmodule

// File: hdl/mam_ctrl_store.sv
// ----------------------------------------------------------------------------
// mam_ctrl_store
// control store and map table, written by load beats and read for the
// next microinstruction and the opcode map
// ----------------------------------------------------------------------------
module mam_ctrl_store (
  input  logic                        clk,
  input  mam_pkg::ld_wr_t             ld,
  input  logic [mam_pkg::UADDR_W-1:0] upc,
  input  logic [mam_pkg::MAP_AW-1:0]  map_idx,
  output mam_pkg::cw_t                cw_next,
  output logic [mam_pkg::UADDR_W-1:0] map_word
);

  logic [mam_pkg::DATA_W-1:0]  store   [mam_pkg::CTRL_WORDS];
  logic [mam_pkg::UADDR_W-1:0] map_mem [mam_pkg::MAP_ENTRIES];
  logic                        cs_ok;
  logic                        map_ok;
  logic                        upc_ok;

  assign cs_ok  = ld.ctrl_en && (int'(ld.addr) < mam_pkg::CTRL_WORDS);
  assign map_ok = ld.map_en && (int'(ld.addr) < mam_pkg::MAP_ENTRIES);
  assign upc_ok = int'(upc) < mam_pkg::CTRL_WORDS;

  always_ff @(posedge clk) begin
    if (cs_ok) begin
      store[ld.addr[mam_pkg::CTRL_AW-1:0]] <= ld.data;
    end
    if (map_ok) begin
      map_mem[ld.addr[mam_pkg::MAP_AW-1:0]] <= ld.data[mam_pkg::UADDR_W-1:0];
    end
  end

  // a control load landing on the same edge is passed straight through
  always_comb begin
    if (!upc_ok) begin
      cw_next = '0;
    end else if (cs_ok && (ld.addr == {{(mam_pkg::ADDR_W-mam_pkg::UADDR_W){1'b0}}, upc})) begin
      cw_next = mam_pkg::cw_t'(ld.data);
    end else begin
      cw_next = mam_pkg::cw_t'(store[upc[mam_pkg::CTRL_AW-1:0]]);
    end
  end

  assign map_word = map_mem[map_idx];

endmodule

// File: hdl/mam_exec.sv
// ----------------------------------------------------------------------------
// mam_exec
// machine registers and the single-pass execute logic for one beat
// ----------------------------------------------------------------------------
module mam_exec (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [mam_pkg::REQ_W-1:0]   req,
  input  logic [mam_pkg::ADDR_W-1:0]  addr,
  input  logic [mam_pkg::DATA_W-1:0]  data,
  input  mam_pkg::cw_t                cw,
  input  logic [mam_pkg::WORD_W-1:0]  ram_rd_data,
  input  logic [mam_pkg::UADDR_W-1:0] map_word,
  output mam_pkg::mach_t              st,
  output mam_pkg::mach_t              st_next,
  output mam_pkg::ram_wr_t            ram_wr,
  output mam_pkg::ld_wr_t             ld_wr,
  output logic [mam_pkg::MAP_AW-1:0]  map_idx,
  output logic [mam_pkg::WORD_W-1:0]  read_data
);

  mam_pkg::mach_t n;
  mam_pkg::cw_t   c;
  logic           step;

  assign step = (req == mam_pkg::REQ_STEP) && !st.halt;
  assign c    = step ? cw : '0;

  always_comb begin
    n     = st;
    n.bus = mam_pkg::bus_drive(c, st);
    if (c.lp) n.pc  = n.bus[mam_pkg::ADDR_W-1:0];
    if (c.lm) n.mar = n.bus[mam_pkg::ADDR_W-1:0];
    if (c.ld) n.mdr = n.bus;
    if (c.li) n.ir  = n.bus;
    if (c.la) n.acc = n.bus;
    if (c.lb) n.b   = n.bus;
    if (c.rd) n.mdr = ram_rd_data;
    if (c.add) n.alu = n.acc + n.b;
    if (c.sub) n.alu = n.acc - n.b;
    if (c.ip) n.pc = n.pc + 8'd1;
    if (step) begin
      n.upc = (c.map && !c.cd) ? map_word : c.jump;
    end
    if (c.hlt) n.halt = 1'b1;
  end

  assign map_idx = n.mdr[8 +: mam_pkg::MAP_AW];
  assign st_next = fire ? n : st;

  always_comb begin
    ram_wr.en   = fire && ((step && c.wr) || (req == mam_pkg::REQ_LOAD_RAM));
    ram_wr.addr = step ? n.mar : addr;
    ram_wr.data = step ? n.mdr : data[mam_pkg::WORD_W-1:0];
  end

  always_comb begin
    ld_wr.ctrl_en = fire && (req == mam_pkg::REQ_LOAD_CTRL);
    ld_wr.map_en  = fire && (req == mam_pkg::REQ_LOAD_MAP);
    ld_wr.addr    = addr;
    ld_wr.data    = data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      read_data <= '0;
    end else if (fire) begin
      st        <= n;
      read_data <= (req == mam_pkg::REQ_READ_RAM) ? ram_rd_data : '0;
    end
  end

endmodule

// File: hdl/microprogrammed_accumulator_machine_core.sv
// ----------------------------------------------------------------------------
// microprogrammed_accumulator_machine_core
// single-bus accumulator machine run one microinstruction per step beat
// path: an input beat is held in the input register and executed into the machine registers
// throughput: one beat per cycle while the result side does not stall, set by
//   the execute pass between the input register and the machine registers
// reset: machine registers, handshake state and main memory written flags
//   clear; control store and map table are not cleared
// ----------------------------------------------------------------------------
module microprogrammed_accumulator_machine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // addr, data
  input  logic [2:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // prog_counter, mem_addr_reg, mem_data_reg,
                                      // accumulator, alu_result, operand_b,
                                      // instr_reg, micro_addr, halted, read_data
);

  logic                        in_valid;
  logic                        out_valid;
  logic                        accept;
  logic                        fire;
  logic [mam_pkg::REQ_W-1:0]   req_q;
  logic [mam_pkg::ADDR_W-1:0]  addr_q;
  logic [mam_pkg::DATA_W-1:0]  data_q;
  mam_pkg::cw_t                cw_q;
  mam_pkg::cw_t                cw_next;
  mam_pkg::mach_t              st;
  mam_pkg::mach_t              st_next;
  mam_pkg::ram_wr_t            ram_wr;
  mam_pkg::ld_wr_t             ld_wr;
  logic [mam_pkg::MAP_AW-1:0]  map_idx;
  logic [mam_pkg::UADDR_W-1:0] map_word;
  logic [mam_pkg::WORD_W-1:0]  ram_rd_data;
  logic [mam_pkg::WORD_W-1:0]  read_data;
  logic [mam_pkg::ADDR_W-1:0]  rd_addr;
  logic [mam_pkg::REQ_W-1:0]   s_req;
  logic [mam_pkg::ADDR_W-1:0]  s_addr;
  logic [mam_pkg::DATA_W-1:0]  s_data;

  assign s_req  = s_axis_tuser;
  assign s_addr = s_axis_tdata[7:0];
  assign s_data = s_axis_tdata[31:8];

  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!in_valid || fire);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= s_req;
      addr_q <= s_addr;
      data_q <= s_data;
      cw_q   <= cw_next;
    end
  end

  // ram address of the incoming beat, seen against the state it will start from
  assign rd_addr = (s_req == mam_pkg::REQ_READ_RAM) ? s_addr
                                                    : mam_pkg::mar_load(cw_next, st_next);

  mam_main_mem u_main_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (ram_wr),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  mam_ctrl_store u_ctrl_store (
    .clk      (clk),
    .ld       (ld_wr),
    .upc      (st_next.upc),
    .map_idx  (map_idx),
    .cw_next  (cw_next),
    .map_word (map_word)
  );

  mam_exec u_exec (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .req         (req_q),
    .addr        (addr_q),
    .data        (data_q),
    .cw          (cw_q),
    .ram_rd_data (ram_rd_data),
    .map_word    (map_word),
    .st          (st),
    .st_next     (st_next),
    .ram_wr      (ram_wr),
    .ld_wr       (ld_wr),
    .map_idx     (map_idx),
    .read_data   (read_data)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, read_data, st.halt, st.upc, st.ir, st.b, st.alu,
                          st.acc, st.mdr, st.mar, st.pc};

endmodule

// File: tb/sv/tb_microprogrammed_accumulator_machine_core.sv
// ----------------------------------------------------------------------------
// tb_microprogrammed_accumulator_machine_core
// self-checking bench for the microprogrammed accumulator machine: a tracker
// class keeps its own copy of the registers, RAM, control store and map table,
// predicts the register dump of every input beat and compares it with each
// result beat; both stream sides idle at random, and the microprogram is
// reloaded at random between steps before a closing halt phase
// ----------------------------------------------------------------------------
module tb_microprogrammed_accumulator_machine_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 2;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_IDLE       = 17;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [mam_pkg::REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [mam_pkg::REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [1:0]                  pad;
    logic [mam_pkg::WORD_W-1:0]  rdata;
    logic                        halt;
    logic [mam_pkg::UADDR_W-1:0] upc;
    logic [mam_pkg::WORD_W-1:0]  ir;
    logic [mam_pkg::WORD_W-1:0]  b;
    logic [mam_pkg::WORD_W-1:0]  alu;
    logic [mam_pkg::WORD_W-1:0]  acc;
    logic [mam_pkg::WORD_W-1:0]  mdr;
    logic [mam_pkg::ADDR_W-1:0]  mar;
    logic [mam_pkg::ADDR_W-1:0]  pc;
  } dump_t;

  class machine_tracker;
    logic [mam_pkg::ADDR_W-1:0]  pc, mar;
    logic [mam_pkg::WORD_W-1:0]  mdr, acc, b, alu, ir, bus;
    logic [mam_pkg::UADDR_W-1:0] upc;
    logic                        halt;
    logic [mam_pkg::WORD_W-1:0]  ram [mam_pkg::RAM_WORDS];
    mam_pkg::cw_t                ctrl [mam_pkg::CTRL_WORDS];
    logic [mam_pkg::UADDR_W-1:0] map_tbl [mam_pkg::MAP_ENTRIES];
    dump_t                       predicted_dumps [$];
    int unsigned                 checked, errors;

    function new();
      pc = '0; mar = '0; mdr = '0; acc = '0; b = '0; alu = '0; ir = '0; bus = '0;
      upc = '0; halt = 1'b0;
      checked = 0; errors = 0;
      foreach (ram[i]) ram[i] = '0;
      foreach (ctrl[i]) ctrl[i] = '0;
      foreach (map_tbl[i]) map_tbl[i] = '0;
    endfunction

    function void run_micro();
      mam_pkg::cw_t w;
      w = (int'(upc) < mam_pkg::CTRL_WORDS) ? ctrl[upc] : '0;
      if (w.ep) bus = {{(mam_pkg::WORD_W-mam_pkg::ADDR_W){1'b0}}, pc};
      if (w.ed) bus = mdr;
      if (w.ei) bus = {{(mam_pkg::WORD_W-mam_pkg::ADDR_W){1'b0}}, ir[mam_pkg::ADDR_W-1:0]};
      if (w.ea) bus = acc;
      if (w.eu) bus = alu;
      if (w.lp) pc = bus[mam_pkg::ADDR_W-1:0];
      if (w.lm) mar = bus[mam_pkg::ADDR_W-1:0];
      if (w.ld) mdr = bus;
      if (w.li) ir = bus;
      if (w.la) acc = bus;
      if (w.lb) b = bus;
      if (w.rd) mdr = (int'(mar) < mam_pkg::RAM_WORDS) ? ram[mar] : '0;
      if (w.wr && int'(mar) < mam_pkg::RAM_WORDS) ram[mar] = mdr;
      if (w.add) alu = acc + b;
      if (w.sub) alu = acc - b;
      if (w.ip) pc = pc + 1'b1;
      if (w.map && !w.cd) upc = map_tbl[mdr[mam_pkg::WORD_W-1:mam_pkg::WORD_W-mam_pkg::MAP_AW]];
      else upc = w.jump;
      if (w.hlt) halt = 1'b1;
    endfunction

    function void take_request(logic [mam_pkg::REQ_W-1:0] req, logic [mam_pkg::ADDR_W-1:0] a,
                               logic [mam_pkg::DATA_W-1:0] d);
      dump_t r;
      logic [mam_pkg::WORD_W-1:0] rdv;
      rdv = '0;
      case (req)
        mam_pkg::REQ_STEP:      if (!halt) run_micro();
        mam_pkg::REQ_LOAD_RAM:
          if (int'(a) < mam_pkg::RAM_WORDS) ram[a] = d[mam_pkg::WORD_W-1:0];
        mam_pkg::REQ_LOAD_CTRL:
          if (int'(a) < mam_pkg::CTRL_WORDS) ctrl[a] = mam_pkg::cw_t'(d);
        mam_pkg::REQ_LOAD_MAP:
          if (int'(a) < mam_pkg::MAP_ENTRIES) map_tbl[a] = d[mam_pkg::UADDR_W-1:0];
        mam_pkg::REQ_READ_RAM:  rdv = (int'(a) < mam_pkg::RAM_WORDS) ? ram[a] : '0;
        default: ;
      endcase
      r = '0;
      r.pc = pc; r.mar = mar; r.mdr = mdr; r.acc = acc; r.alu = alu;
      r.b = b; r.ir = ir; r.upc = upc; r.halt = halt; r.rdata = rdv;
      predicted_dumps.push_back(r);
    endfunction

    function bit differs(string name, logic [mam_pkg::WORD_W-1:0] e,
                         logic [mam_pkg::WORD_W-1:0] a);
      if (e !== a && errors < REPORT_LIMIT)
        $display("result %0d %s: expected %0h, got %0h", checked, name, e, a);
      return e !== a;
    endfunction

    function void check_dump(logic [95:0] raw);
      dump_t got, want;
      bit bad;
      got = raw;
      if (predicted_dumps.size() == 0) begin
        if (errors < REPORT_LIMIT) $display("result beat with nothing predicted: %h", raw);
        errors++;
        return;
      end
      want = predicted_dumps.pop_front();
      bad = 1'b0;
      bad |= differs("prog_counter", want.pc, got.pc);
      bad |= differs("mem_addr_reg", want.mar, got.mar);
      bad |= differs("mem_data_reg", want.mdr, got.mdr);
      bad |= differs("accumulator", want.acc, got.acc);
      bad |= differs("alu_result", want.alu, got.alu);
      bad |= differs("operand_b", want.b, got.b);
      bad |= differs("instr_reg", want.ir, got.ir);
      bad |= differs("micro_addr", want.upc, got.upc);
      bad |= differs("halted", want.halt, got.halt);
      bad |= differs("read_data", want.rdata, got.rdata);
      if (bad) errors++;
      checked++;
    endfunction

    function int pending();
      return predicted_dumps.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;

  machine_tracker sb = new();
  int unsigned n_step, n_load, n_read, n_spare;
  int unsigned idle_cycles;
  bit send_burst, recv_burst;

  microprogrammed_accumulator_machine_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no beat on either side for %0d cycles", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [mam_pkg::REQ_W-1:0] req,
                          input logic [mam_pkg::ADDR_W-1:0] a,
                          input logic [mam_pkg::DATA_W-1:0] d);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d, a};
    s_axis_tuser  <= req;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_request(req, a, d);
    case (req)
      mam_pkg::REQ_STEP: n_step++;
      mam_pkg::REQ_LOAD_RAM, mam_pkg::REQ_LOAD_CTRL, mam_pkg::REQ_LOAD_MAP: n_load++;
      mam_pkg::REQ_READ_RAM: n_read++;
      default: n_spare++;
    endcase
  endtask

  // loads a word where the machine will fetch next, then steps it
  task automatic run_word(input mam_pkg::cw_t w);
    send_req(mam_pkg::REQ_LOAD_CTRL, mam_pkg::ADDR_W'(sb.upc), mam_pkg::DATA_W'(w));
    send_req(mam_pkg::REQ_STEP, '0, mam_pkg::DATA_W'($urandom));
  endtask

  task automatic directed_part();
    mam_pkg::cw_t w;
    send_req(mam_pkg::REQ_LOAD_RAM, 8'h00, 24'hffffff);
    send_req(mam_pkg::REQ_LOAD_RAM, 8'hff, 24'h000000);
    send_req(mam_pkg::REQ_READ_RAM, 8'h00, 24'h000000);
    send_req(mam_pkg::REQ_READ_RAM, 8'hff, 24'hffffff);
    send_req(mam_pkg::REQ_LOAD_CTRL, 8'(mam_pkg::CTRL_WORDS), 24'hffffff);
    send_req(mam_pkg::REQ_LOAD_CTRL, 8'hff, 24'hffffff);
    send_req(mam_pkg::REQ_LOAD_MAP, 8'(mam_pkg::MAP_ENTRIES), 24'hffffff);
    send_req(mam_pkg::REQ_LOAD_MAP, 8'hff, 24'hffffff);
    send_req(mam_pkg::REQ_LOAD_MAP, 8'(mam_pkg::MAP_ENTRIES - 1), 24'hffffff);
    for (int r = REQ_SPARE_FIRST; r <= REQ_SPARE_LAST; r++)
      send_req(mam_pkg::REQ_W'(r), 8'hff, 24'hffffff);
    // ram read into mdr
    w = '0; w.rd = 1'b1; w.jump = mam_pkg::UADDR_W'($urandom);
    run_word(w);
    // pc loaded with all ones then incremented past the top
    w = '0; w.ed = 1'b1; w.lp = 1'b1; w.ip = 1'b1; w.la = 1'b1;
    w.jump = mam_pkg::UADDR_W'($urandom);
    run_word(w);
    // nothing drives the bus, add and subtract together
    w = '0; w.lb = 1'b1; w.add = 1'b1; w.sub = 1'b1; w.jump = mam_pkg::UADDR_W'($urandom);
    run_word(w);
    // every enable at once
    w = '0; w.ep = 1'b1; w.ed = 1'b1; w.ei = 1'b1; w.ea = 1'b1; w.eu = 1'b1;
    w.lm = 1'b1; w.li = 1'b1; w.jump = mam_pkg::UADDR_W'($urandom);
    run_word(w);
    // cd over map, then map alone
    w = '0; w.cd = 1'b1; w.map = 1'b1; w.jump = mam_pkg::UADDR_W'($urandom);
    run_word(w);
    w = '0; w.map = 1'b1; w.jump = mam_pkg::UADDR_W'($urandom);
    run_word(w);
    w = '0; w.wr = 1'b1; w.ea = 1'b1; w.lb = 1'b1; w.add = 1'b1;
    w.jump = mam_pkg::UADDR_W'($urandom);
    run_word(w);
  endtask

  task automatic random_req();
    int pick;
    logic [mam_pkg::ADDR_W-1:0] a;
    logic [mam_pkg::DATA_W-1:0] d;
    mam_pkg::cw_t w;
    pick = $urandom_range(0, 99);
    a = mam_pkg::ADDR_W'($urandom);
    d = mam_pkg::DATA_W'($urandom);
    if (pick < 68) begin
      send_req(mam_pkg::REQ_STEP, a, d);
    end else if (pick < 78) begin
      if ($urandom_range(0, 1) != 0) a = sb.mar;
      send_req(mam_pkg::REQ_LOAD_RAM, a, d);
    end else if (pick < 84) begin
      if ($urandom_range(0, 9) != 0)
        a = mam_pkg::ADDR_W'($urandom_range(0, mam_pkg::CTRL_WORDS - 1));
      w = mam_pkg::cw_t'(d);
      w.hlt = 1'b0;
      send_req(mam_pkg::REQ_LOAD_CTRL, a, mam_pkg::DATA_W'(w));
    end else if (pick < 89) begin
      if ($urandom_range(0, 9) != 0)
        a = mam_pkg::ADDR_W'($urandom_range(0, mam_pkg::MAP_ENTRIES - 1));
      send_req(mam_pkg::REQ_LOAD_MAP, a, d);
    end else if (pick < 97) begin
      if ($urandom_range(0, 1) != 0) a = sb.mar;
      send_req(mam_pkg::REQ_READ_RAM, a, d);
    end else begin
      send_req(mam_pkg::REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)), a, d);
    end
  endtask

  task automatic halt_phase();
    mam_pkg::cw_t w;
    for (int i = 0; i < mam_pkg::CTRL_WORDS; i++) begin
      w = mam_pkg::cw_t'(mam_pkg::DATA_W'($urandom));
      w.hlt = 1'b1;
      send_req(mam_pkg::REQ_LOAD_CTRL, mam_pkg::ADDR_W'(i), mam_pkg::DATA_W'(w));
    end
    repeat (4) send_req(mam_pkg::REQ_STEP, mam_pkg::ADDR_W'($urandom),
                        mam_pkg::DATA_W'($urandom));
    send_req(mam_pkg::REQ_LOAD_RAM, sb.mar, mam_pkg::DATA_W'($urandom));
    send_req(mam_pkg::REQ_READ_RAM, sb.mar, mam_pkg::DATA_W'($urandom));
    send_req(mam_pkg::REQ_LOAD_MAP,
             mam_pkg::ADDR_W'($urandom_range(0, mam_pkg::MAP_ENTRIES - 1)),
             mam_pkg::DATA_W'($urandom));
    send_req(mam_pkg::REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)),
             mam_pkg::ADDR_W'($urandom), mam_pkg::DATA_W'($urandom));
    repeat (2) send_req(mam_pkg::REQ_STEP, mam_pkg::ADDR_W'($urandom),
                        mam_pkg::DATA_W'($urandom));
  endtask

  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_dump(m_axis_tdata);
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    // every control word and map entry is written before the first fetch
    for (int i = 0; i < mam_pkg::CTRL_WORDS; i++) begin
      mam_pkg::cw_t w;
      w = mam_pkg::cw_t'(mam_pkg::DATA_W'($urandom));
      w.hlt = 1'b0;
      send_req(mam_pkg::REQ_LOAD_CTRL, mam_pkg::ADDR_W'(i), mam_pkg::DATA_W'(w));
    end
    for (int i = 0; i < mam_pkg::MAP_ENTRIES; i++)
      send_req(mam_pkg::REQ_LOAD_MAP, mam_pkg::ADDR_W'(i), mam_pkg::DATA_W'($urandom));
    directed_part();
    repeat (RANDOM_ITEMS) random_req();
    halt_phase();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d steps, %0d memory loads, %0d ram reads, %0d unused request codes",
             n_step, n_load, n_read, n_spare);
    $display("%0d register dumps compared, %0d wrong, %0d left over, machine %s",
             sb.checked, sb.errors, sb.pending(), sb.halt ? "halted" : "running");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
